// ===== hw/rtl/rtsq_pkg.sv =====
`default_nettype none
package rtsq_pkg;

  // Window geometry
  localparam int WINDOW_LEN = 8;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

  // Field widths
  localparam int ADC_W   = 12;
  localparam int REF_W   = 16;
  localparam int HOLD_W  = 8;
  localparam int RES_W   = 17;
  localparam int CLS_W   = 3;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = RES_W + 1;
  localparam int SUM_W   = RES_W + FILL_W;

  // Shared divider: ref*code over (full scale - code), or sum over count
  localparam int DIV_W  = REF_W + ADC_W;
  localparam int DEN_W  = ADC_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RES_W;

  localparam logic [CFG_IDX_W-1:0] CFG_REF        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_HI  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_MID = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_LO  = CFG_IDX_W'(5);

  localparam logic [REF_W-1:0]  REF_RESET       = REF_W'(10000);
  localparam logic [HOLD_W-1:0] HOLD_RESET      = HOLD_W'(3);
  localparam logic [RES_W-1:0]  THRESH_HI_RESET  = RES_W'(10000);
  localparam logic [RES_W-1:0]  THRESH_MID_RESET = RES_W'(5000);
  localparam logic [RES_W-1:0]  THRESH_LO_RESET  = RES_W'(1500);

  localparam logic [ADC_W-1:0] ADC_FULL = ADC_W'(4095);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_READ   = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SAMPLE = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_CLEAR  = KIND_W'(2);

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_EMPTY  = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_LOCKED = STAT_W'(2);

  // Piece classes
  localparam logic [CLS_W-1:0] CLS_NONE = CLS_W'(0);
  localparam logic [CLS_W-1:0] CLS_LOW  = CLS_W'(1);
  localparam logic [CLS_W-1:0] CLS_MID  = CLS_W'(2);
  localparam logic [CLS_W-1:0] CLS_HIGH = CLS_W'(3);
  localparam logic [CLS_W-1:0] CLS_TOP  = CLS_W'(4);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADC_W-1:0]  adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [RES_W-1:0]  average_resistance;
    logic [CLS_W-1:0]  piece_class;
    logic              changed;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_RDIV,
    S_RWAIT,
    S_WRITE,
    S_SUM,
    S_AVG,
    S_AWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul;
    logic div_start;
    logic div_sel;
    logic write_entry;
    logic rd_issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              locked;
    logic              code_full;
    logic              walk_done;
    logic              div_done;
    logic              sum_zero;
    logic              out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/resistive_tile_sensor_qualifier.sv =====
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_data  (kind, adc_sample)
// out       out_valid / out_ready out_data (status, average_resistance,
//                                           piece_class, changed)
// cfg       cfg_we                cfg_index, cfg_data
//
// Reading: accept, multiply, divider start, divider steps until done, window
// write; code 4095 skips the divider.
// Sample: accept, window walk with RAM reads, divider start, divider wait,
// emit; locked goes straight to emit, a zero sum skips the divider.
// Reset clears control and class state and loads register defaults; a result
// waiting on out_ready stalls the next sample in its emit cycle.
`default_nettype none
module resistive_tile_sensor_qualifier (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rtsq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rtsq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire rtsq_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output rtsq_pkg::out_item_t                   out_data
);

  import rtsq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  rtsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rtsq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rtsq_ram.sv =====
`default_nettype none
module rtsq_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rtsq_div.sv =====
`default_nettype none
module rtsq_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rtsq_pkg::DIV_W-1:0]  dividend,
  input  wire logic [rtsq_pkg::DEN_W-1:0]  divisor,
  output logic                             done,
  output logic      [rtsq_pkg::DIV_W-1:0]  quotient
);

  import rtsq_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, den});

  // Control: count quotient bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        busy  <= (steps != STEP_W'(1));
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rtsq_dp.sv =====
`default_nettype none
module rtsq_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rtsq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rtsq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire rtsq_pkg::in_item_t               in_data,
  input  wire rtsq_pkg::ctrl_cmd_t              cmd,
  output rtsq_pkg::dp_status_t                  st,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output rtsq_pkg::out_item_t                   out_data
);

  import rtsq_pkg::*;

  // Configuration registers
  logic [REF_W-1:0]  ref_res;
  logic [HOLD_W-1:0] hold_count;
  logic              lock_en;
  logic [RES_W-1:0]  th_high;
  logic [RES_W-1:0]  th_mid;
  logic [RES_W-1:0]  th_low;

  // Item and walk registers
  logic [ADC_W-1:0]  code;
  logic [DIV_W-1:0]  prod;
  logic [IDX_W-1:0]  head;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] idx;
  logic              rd_pend;
  logic [SUM_W-1:0]  sum;
  logic [FILL_W-1:0] cnt;

  // Class tracking
  logic [CLS_W-1:0]  occ;
  logic [CLS_W-1:0]  prev;
  logic [HOLD_W-1:0] rticks;
  logic              locked;

  logic [RES_W-1:0]   limit2;
  logic [DIV_W-1:0]   div_dividend;
  logic [DEN_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   quotient;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] rdata;
  logic               conn;
  logic [RES_W-1:0]   avg;
  logic [CLS_W-1:0]   cls;
  logic [HOLD_W-1:0]  rticks_next;
  logic [CLS_W-1:0]   occ_next;
  logic               locked_next;
  logic               chg;

  assign limit2 = {ref_res, 1'b0};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_res    <= REF_RESET;
      hold_count <= HOLD_RESET;
      lock_en    <= 1'b0;
      th_high    <= THRESH_HI_RESET;
      th_mid     <= THRESH_MID_RESET;
      th_low     <= THRESH_LO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF:        ref_res    <= cfg_data[REF_W-1:0];
        CFG_HOLD:       hold_count <= cfg_data[HOLD_W-1:0];
        CFG_LOCK:       lock_en    <= cfg_data[0];
        CFG_THRESH_HI:  th_high    <= cfg_data[RES_W-1:0];
        CFG_THRESH_MID: th_mid     <= cfg_data[RES_W-1:0];
        CFG_THRESH_LO:  th_low     <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Select divider operands: reading conversion or window average
  always_comb begin
    if (cmd.div_sel) begin
      div_dividend = DIV_W'(sum);
      div_divisor  = DEN_W'(cnt);
    end else begin
      div_dividend = prod;
      div_divisor  = ADC_FULL - code;
    end
  end

  rtsq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Build the window entry: full scale or open circuit stores as disconnected
  assign conn  = (code != ADC_FULL) && (quotient <= DIV_W'(limit2));
  assign entry = conn ? {1'b1, quotient[RES_W-1:0]} : '0;

  rtsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (cmd.write_entry),
    .waddr (head),
    .wdata (entry),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Capture the item, multiply, walk and accumulate the window
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code <= in_data.adc_sample;
      sum  <= '0;
      cnt  <= '0;
      idx  <= '0;
    end else begin
      if (cmd.rd_issue) begin
        idx <= idx + FILL_W'(1);
      end
      if (rd_pend && rdata[RES_W]) begin
        sum <= sum + SUM_W'(rdata[RES_W-1:0]);
        cnt <= cnt + FILL_W'(1);
      end
    end
    if (cmd.mul) begin
      prod <= DIV_W'(ref_res) * DIV_W'(code);
    end
  end

  // Classify the average
  assign avg = quotient[RES_W-1:0];

  always_comb begin
    if (avg >= limit2) begin
      cls = CLS_NONE;
    end else if (avg > th_high) begin
      cls = CLS_TOP;
    end else if (avg > th_mid) begin
      cls = CLS_HIGH;
    end else if (avg > th_low) begin
      cls = CLS_MID;
    end else begin
      cls = CLS_LOW;
    end
  end

  // Debounce: a new class must repeat past hold_count before it is taken
  always_comb begin
    rticks_next = rticks;
    occ_next    = occ;
    locked_next = locked;
    chg         = 1'b0;
    if (cls != occ) begin
      if (cls == prev) begin
        if (rticks != '1) begin
          rticks_next = rticks + HOLD_W'(1);
        end
        if (rticks_next > hold_count) begin
          chg      = 1'b1;
          occ_next = cls;
          if (lock_en && (cls != CLS_NONE)) begin
            locked_next = 1'b1;
          end
        end
      end
    end else begin
      rticks_next = '0;
    end
  end

  // Window pointers and class state
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      fill    <= '0;
      occ     <= CLS_NONE;
      prev    <= CLS_NONE;
      rticks  <= '0;
      locked  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      if (cmd.clear) begin
        head   <= '0;
        fill   <= '0;
        occ    <= CLS_NONE;
        prev   <= CLS_NONE;
        locked <= 1'b0;
      end else if (cmd.write_entry) begin
        head <= (head == IDX_W'(WINDOW_LEN - 1)) ? '0 : head + IDX_W'(1);
        if (fill != FILL_W'(WINDOW_LEN)) begin
          fill <= fill + FILL_W'(1);
        end
      end else if (cmd.emit && !locked && (sum != '0)) begin
        rticks <= rticks_next;
        occ    <= occ_next;
        prev   <= cls;
        locked <= locked_next;
      end
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (locked) begin
        out_data <= '{status: STAT_LOCKED, average_resistance: '0,
                      piece_class: occ, changed: 1'b0};
      end else if (sum == '0) begin
        out_data <= '{status: STAT_EMPTY, average_resistance: '0,
                      piece_class: occ, changed: 1'b0};
      end else begin
        out_data <= '{status: STAT_OK, average_resistance: avg,
                      piece_class: occ_next, changed: chg};
      end
    end
  end

  // Status to the controller
  always_comb begin
    st.kind      = in_data.kind;
    st.locked    = locked;
    st.code_full = (code == ADC_FULL);
    st.walk_done = (idx == fill);
    st.div_done  = div_done;
    st.sum_zero  = (sum == '0);
    st.out_busy  = out_valid && !out_ready;
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW_LEN))
    else $error("window fill beyond window length");

  a_lock_has_piece: assert property (@(posedge clk) disable iff (rst)
    locked |-> (occ != CLS_NONE))
    else $error("channel locked with no piece");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result beat not presented after emit");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (idx < fill))
    else $error("window read past fill");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/rtsq_ctrl.sv =====
`default_nettype none
module rtsq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rtsq_pkg::dp_status_t  st,
  output rtsq_pkg::ctrl_cmd_t        cmd
);

  import rtsq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (st.kind)
            KIND_READ:   state_next = st.locked ? S_IDLE : S_MUL;
            KIND_SAMPLE: state_next = st.locked ? S_EMIT : S_SUM;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_MUL:   state_next = st.code_full ? S_WRITE : S_RDIV;
      S_RDIV:  state_next = S_RWAIT;
      S_RWAIT: state_next = st.div_done ? S_WRITE : S_RWAIT;
      S_WRITE: state_next = S_IDLE;
      S_SUM:   state_next = st.walk_done ? S_AVG : S_SUM;
      S_AVG:   state_next = st.sum_zero ? S_EMIT : S_AWAIT;
      S_AWAIT: state_next = st.div_done ? S_EMIT : S_AWAIT;
      S_EMIT:  state_next = st.out_busy ? S_EMIT : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        cmd.clear = in_valid && (st.kind == KIND_CLEAR);
      end
      S_MUL:   cmd.mul = 1'b1;
      S_RDIV:  cmd.div_start = 1'b1;
      S_WRITE: cmd.write_entry = 1'b1;
      S_SUM:   cmd.rd_issue = !st.walk_done;
      S_AVG: begin
        cmd.div_start = !st.sum_zero;
        cmd.div_sel   = 1'b1;
      end
      S_AWAIT: cmd.div_sel = 1'b1;
      S_EMIT:  cmd.emit = !st.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/resistive_tile_sensor_qualifier_tb.sv =====
`timescale 1ns / 1ps
module resistive_tile_sensor_qualifier_tb;
  import rtsq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_IGNORED = KIND_W'(3);
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;

  // Tracks one sensor channel and holds the reports that samples must produce
  class channel_scoreboard;
    logic [REF_W-1:0]   ref_ohms;
    logic [HOLD_W-1:0]  hold;
    logic               lock_en;
    logic [RES_W-1:0]   thr_hi;
    logic [RES_W-1:0]   thr_mid;
    logic [RES_W-1:0]   thr_lo;
    logic [ENTRY_W-1:0] window [WINDOW_LEN];
    int unsigned        fill;
    int unsigned        head;
    logic [CLS_W-1:0]   occupant;
    logic [CLS_W-1:0]   prev_cls;
    logic [HOLD_W-1:0]  ticks;
    logic               locked;
    out_item_t          expected_reports [$];
    int                 failures;

    function new();
      ref_ohms = REF_RESET;
      hold     = HOLD_RESET;
      lock_en  = 1'b0;
      thr_hi   = THRESH_HI_RESET;
      thr_mid  = THRESH_MID_RESET;
      thr_lo   = THRESH_LO_RESET;
      ticks    = '0;
      failures = 0;
      clear_channel();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_REF:        ref_ohms = val[REF_W-1:0];
        CFG_HOLD:       hold     = val[HOLD_W-1:0];
        CFG_LOCK:       lock_en  = val[0];
        CFG_THRESH_HI:  thr_hi   = val;
        CFG_THRESH_MID: thr_mid  = val;
        CFG_THRESH_LO:  thr_lo   = val;
        default: ;
      endcase
    endfunction

    function void clear_channel();
      foreach (window[i]) window[i] = '0;
      fill     = 0;
      head     = 0;
      occupant = CLS_NONE;
      prev_cls = CLS_NONE;
      locked   = 1'b0;
    endfunction

    function logic [CLS_W-1:0] band_of(int unsigned avg);
      int unsigned limit;
      limit = 2 * ref_ohms;
      if (avg >= limit) return CLS_NONE;
      if (avg > thr_hi) return CLS_TOP;
      if (avg > thr_mid) return CLS_HIGH;
      if (avg > thr_lo) return CLS_MID;
      return CLS_LOW;
    endfunction

    // Convert a code to ohms and push it into the window, flagged open or connected
    function void store_reading(logic [ADC_W-1:0] code);
      longint unsigned ohms;
      logic [ENTRY_W-1:0] entry;
      entry = '0;
      if (code != ADC_FULL) begin
        ohms = (64'(ref_ohms) * 64'(code)) / 64'(ADC_FULL - code);
        if (ohms <= 2 * longint'(ref_ohms)) entry = {1'b1, RES_W'(ohms)};
      end
      window[head] = entry;
      head = (head + 1) % WINDOW_LEN;
      if (fill < WINDOW_LEN) fill++;
    endfunction

    // Average the window, debounce the class and build the report
    function out_item_t sample_report();
      int unsigned sum;
      int unsigned count;
      int unsigned avg;
      logic [CLS_W-1:0] band;
      out_item_t rep;
      rep = '0;
      rep.piece_class = occupant;
      if (locked) begin
        rep.status = STAT_LOCKED;
        return rep;
      end
      sum = 0;
      count = 0;
      for (int i = 0; i < fill; i++) begin
        if (window[i][RES_W]) begin
          sum += window[i][RES_W-1:0];
          count++;
        end
      end
      if (count == 0 || sum == 0) begin
        rep.status = STAT_EMPTY;
        return rep;
      end
      avg  = sum / count;
      band = band_of(avg);
      if (band != occupant) begin
        if (band == prev_cls) begin
          if (ticks != '1) ticks++;
          if (ticks > hold) begin
            rep.changed = 1'b1;
            occupant = band;
            if (lock_en && band != CLS_NONE) locked = 1'b1;
          end
        end
      end else begin
        ticks = '0;
      end
      prev_cls = band;
      rep.status = STAT_OK;
      rep.average_resistance = RES_W'(avg);
      rep.piece_class = occupant;
      return rep;
    endfunction

    function void note_item(in_item_t item);
      case (item.kind)
        KIND_READ:   if (!locked) store_reading(item.adc_sample);
        KIND_CLEAR:  clear_channel();
        KIND_SAMPLE: expected_reports.insert(expected_reports.size(), sample_report());
        default: ;
      endcase
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    function void check_report(out_item_t got);
      out_item_t exp;
      if (expected_reports.size() == 0) begin
        flag($sformatf("unexpected report: status %0d avg %0d class %0d changed %0d",
                       got.status, got.average_resistance, got.piece_class, got.changed));
        return;
      end
      exp = expected_reports[0];
      expected_reports.delete(0);
      if (got.status !== exp.status || got.average_resistance !== exp.average_resistance ||
          got.piece_class !== exp.piece_class || got.changed !== exp.changed)
        flag($sformatf({"report mismatch: expected status %0d avg %0d class %0d changed %0d,",
                        " got status %0d avg %0d class %0d changed %0d"},
                       exp.status, exp.average_resistance, exp.piece_class, exp.changed,
                       got.status, got.average_resistance, got.piece_class, got.changed));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  channel_scoreboard sb = new();

  int burst_left = 0;
  int gap_max = 0;
  int stall_max = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int random_items = 0;
  int quiet_cycles = 0;

  resistive_tile_sensor_qualifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note input beats and check result beats at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_item(in_data);
    if (!rst && out_valid && out_ready) sb.check_report(out_data);
  end

  // Stall the result side in random stretches
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (stall_max != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(0, stall_max - 1);
    end else begin
      out_ready = 1'b1;
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one item, in bursts with random gaps; call and return at a falling edge
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADC_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data.kind = kind;
    in_data.adc_sample = code;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (kind != KIND_IGNORED) random_items++;
  endtask

  // Drop valid, let every report arrive, then let a pending reading finish
  task automatic wait_idle();
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    sb.set_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic config_channel(input int unsigned ohms, input int unsigned hold,
                                input int unsigned lock, input int unsigned hi,
                                input int unsigned mid, input int unsigned lo);
    write_reg(CFG_REF, ohms);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_LOCK, lock);
    write_reg(CFG_THRESH_HI, hi);
    write_reg(CFG_THRESH_MID, mid);
    write_reg(CFG_THRESH_LO, lo);
  endtask

  // Spread three ordered thresholds over the usable resistance span
  task automatic config_banded(input int unsigned ohms, input int unsigned hold,
                               input int unsigned lock);
    int unsigned span;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned t;
    span = (2 * ohms > 131071) ? 131071 : 2 * ohms;
    a = $urandom_range(0, span);
    b = $urandom_range(0, span);
    c = $urandom_range(0, span);
    if (a < b) begin t = a; a = b; b = t; end
    if (b < c) begin t = b; b = c; c = t; end
    if (a < b) begin t = a; a = b; b = t; end
    config_channel(ohms, hold, lock, a, b, c);
  endtask

  // Mostly a tile placed: readings near one code, then a run of samples
  task automatic run_random(input int quota);
    int pick;
    int base;
    int code;
    random_items = 0;
    while (random_items < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        base = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 3100))
                                            : int'($urandom_range(0, 4095));
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 99) < 10) begin
            code = ($urandom_range(0, 1) != 0) ? 4095 : int'($urandom_range(0, 4095));
          end else begin
            code = base + int'($urandom_range(0, 16)) - 8;
            if (code < 0) code = 0;
            if (code > 4095) code = 4095;
          end
          send_item(KIND_READ, ADC_W'(code));
        end
        repeat ($urandom_range(1, sb.hold + 3)) send_item(KIND_SAMPLE, ADC_W'($urandom));
        if ($urandom_range(0, 99) < 15) send_item(KIND_CLEAR, ADC_W'($urandom));
      end else if (pick < 87) begin
        send_item(KIND_W'($urandom_range(0, 3)), ADC_W'($urandom));
      end else if (pick < 93) begin
        send_item(KIND_CLEAR, ADC_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_item(KIND_SAMPLE, ADC_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: register defaults, empty and zero-sum windows, open and full-scale codes
    send_item(KIND_SAMPLE, '0);
    send_item(KIND_IGNORED, '1);
    send_item(KIND_READ, ADC_W'(0));
    send_item(KIND_SAMPLE, '0);
    send_item(KIND_READ, ADC_W'(4095));
    send_item(KIND_READ, ADC_W'(4094));
    send_item(KIND_SAMPLE, '1);
    send_item(KIND_READ, ADC_W'(2730));
    send_item(KIND_READ, ADC_W'(2731));
    send_item(KIND_READ, ADC_W'(2000));
    repeat (5) send_item(KIND_SAMPLE, '0);
    send_item(KIND_CLEAR, '0);
    send_item(KIND_SAMPLE, '0);

    // Directed: lock on the first accepted class, ignore readings, unlock on clear
    wait_idle();
    config_channel(10000, 0, 1, 10000, 5000, 1500);
    send_item(KIND_READ, ADC_W'(1000));
    send_item(KIND_SAMPLE, '0);
    send_item(KIND_SAMPLE, '0);
    send_item(KIND_READ, ADC_W'(3000));
    send_item(KIND_SAMPLE, '0);
    send_item(KIND_CLEAR, '0);
    send_item(KIND_SAMPLE, '0);

    // Random phases over several settings, extremes included
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: config_channel(10000, 3, 0, 10000, 5000, 1500);
        1: config_banded(1, 0, 0);
        2: config_channel(65535, 255, 0, 131071, 131071, 131071);
        3: config_banded(65535, 2, 1);
        4: config_channel($urandom_range(1, 65535), 0, 1, 0, 0, 0);
        default: config_banded($urandom_range(1, 65535), $urandom_range(0, 8),
                               $urandom_range(0, 1));
      endcase
      gap_max   = (p % 3 == 0) ? 0 : $urandom_range(2, 20);
      stall_max = (p == 0) ? 0 : $urandom_range(1, 60);
      stall_pct = $urandom_range(5, 50);
      run_random((p == 2) ? 400 : 205);
    end

    wait_idle();
    if (sb.expected_reports.size() != 0)
      sb.flag($sformatf("%0d reports never arrived", sb.expected_reports.size()));
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
